/* hdl/wts_pkg.sv */
package wts_pkg;

  localparam int MaxPixels = 256;
  localparam int PixW      = $clog2(MaxPixels + 1);
  localparam int BytesW    = $clog2(3 * MaxPixels + 1);
  localparam int PhaseW    = 5;
  localparam int SlotW     = 4;

  localparam int PreambleEnd = 10;
  localparam int ZeroEnd     = 8;
  localparam int OneEnd      = 16;
  localparam int BitEnd      = 25;
  localparam int LastSlot    = 8;

  localparam logic [8:0] LedCountReset = 9'd8;

  typedef enum logic [1:0] {
    OP_TICK   = 2'd0,
    OP_SET    = 2'd1,
    OP_UPDATE = 2'd2
  } opcode_e;

  // byte lane of the frame colour, from the byte count modulo three
  typedef enum logic [1:0] {
    LANE_GREEN = 2'd0,
    LANE_BLUE  = 2'd1,
    LANE_RED   = 2'd2
  } lane_e;

  typedef struct packed {
    logic              tick;
    logic              load;
    logic [BytesW-1:0] load_bytes;
  } wts_cmd_t;

  typedef struct packed {
    logic line;
    logic busy;
  } wts_stat_t;

endpackage

/* hdl/wts_core.sv */
module wts_core
  import wts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  wts_cmd_t    cmd_i,
  input  logic [23:0] frame_colour_i,
  output wts_stat_t   stat_o
);

  logic [BytesW-1:0] bytes_q, bytes_d;
  lane_e             lane_q, lane_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [PhaseW-1:0] phase_q, phase_d;
  logic              running_q, running_d;
  logic              line_q, line_d;

  logic [7:0] cur_byte;
  logic [2:0] bit_idx;
  logic       cur_bit;

  always_comb begin
    case (lane_q)
      LANE_GREEN: cur_byte = frame_colour_i[23:16];
      LANE_RED:   cur_byte = frame_colour_i[15:8];
      LANE_BLUE:  cur_byte = frame_colour_i[7:0];
      default:    cur_byte = 8'd0;
    endcase
  end

  // slot 1 is the MSB, slot 8 the LSB
  assign bit_idx = 3'(SlotW'(LastSlot) - slot_q);
  assign cur_bit = (slot_q >= SlotW'(1)) && (slot_q <= SlotW'(LastSlot)) && cur_byte[bit_idx];

  always_comb begin
    bytes_d   = bytes_q;
    lane_d    = lane_q;
    slot_d    = slot_q;
    phase_d   = phase_q;
    running_d = running_q;
    line_d    = line_q;
    if (cmd_i.load) begin
      bytes_d   = cmd_i.load_bytes;
      lane_d    = LANE_GREEN;
      running_d = 1'b1;
    end else if (cmd_i.tick && running_q) begin
      if (bytes_q == '0) begin
        slot_d    = '0;
        phase_d   = '0;
        running_d = 1'b0;
      end else if (slot_q == '0) begin
        line_d = 1'b0;
        if (phase_q >= PhaseW'(PreambleEnd)) begin
          slot_d  = SlotW'(1);
          phase_d = PhaseW'(1);
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end else begin
        line_d = (phase_q <= PhaseW'(ZeroEnd)) ||
                 (cur_bit && (phase_q <= PhaseW'(OneEnd)));
        if (phase_q >= PhaseW'(BitEnd)) begin
          phase_d = PhaseW'(1);
          if (slot_q >= SlotW'(LastSlot)) begin
            slot_d  = SlotW'(1);
            bytes_d = bytes_q - BytesW'(1);
            // track the count modulo three: 0 -> 2 -> 1 -> 0
            case (lane_q)
              LANE_GREEN: lane_d = LANE_RED;
              LANE_RED:   lane_d = LANE_BLUE;
              LANE_BLUE:  lane_d = LANE_GREEN;
              default:    lane_d = LANE_GREEN;
            endcase
          end else begin
            slot_d = slot_q + SlotW'(1);
          end
        end else begin
          phase_d = phase_q + PhaseW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q   <= '0;
      lane_q    <= LANE_GREEN;
      slot_q    <= '0;
      phase_q   <= '0;
      running_q <= 1'b0;
      line_q    <= 1'b0;
    end else begin
      bytes_q   <= bytes_d;
      lane_q    <= lane_d;
      slot_q    <= slot_d;
      phase_q   <= phase_d;
      running_q <= running_d;
      line_q    <= line_d;
    end
  end

  assign stat_o.line = line_q;
  assign stat_o.busy = running_q;

endmodule

/* hdl/ws2812_tick_serializer.sv */
// Channel  | Handshake                  | Payload
// ---------+----------------------------+------------------------------------
// in       | in_valid_i / in_ready_o    | opcode_i, red_i, green_i, blue_i
// out      | out_valid_o / out_ready_i  | line_level_o, busy_res_o
// cfg      | psel/penable/pwrite/pready | paddr, pwdata, prdata (led_count)
//
// One request per clock unless a stalled result holds in_ready_o low; each
// result shows in the cycle after its request. The waveform state registers
// are the result register, so in_ready_o drops only while a result waits and
// out_ready_i is low. Reset clears all state; led_count comes up at 8.
module ws2812_tick_serializer
  import wts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        line_level_o,
  output logic        busy_res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  led_cnt_q;
  logic [23:0] stored_q, stored_d;
  logic [23:0] frame_q, frame_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  logic        cfg_wr;
  logic [PixW-1:0] n_px;
  wts_cmd_t    cmd;
  wts_stat_t   stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {23'd0, led_cnt_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_cnt_q <= LedCountReset;
    end else if (cfg_wr) begin
      led_cnt_q <= pwdata[8:0];
    end
  end

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // saturate the pixel count, then three bytes per pixel
  assign n_px = (32'(led_cnt_q) > 32'(MaxPixels)) ? PixW'(MaxPixels) : PixW'(led_cnt_q);

  always_comb begin
    stored_d       = stored_q;
    frame_d        = frame_q;
    cmd.tick       = 1'b0;
    cmd.load       = 1'b0;
    cmd.load_bytes = BytesW'({n_px, 1'b0}) + BytesW'(n_px);
    if (in_acc) begin
      case (opcode_e'(opcode_i))
        OP_TICK:   cmd.tick = 1'b1;
        OP_SET:    stored_d = {green_i, red_i, blue_i};
        OP_UPDATE: begin
          frame_d  = stored_q;
          cmd.load = 1'b1;
        end
        default:   ;
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (in_acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q    <= '0;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      stored_q    <= stored_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
    end
  end

  wts_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .frame_colour_i (frame_q),
    .stat_o         (stat)
  );

  assign out_valid_o  = out_valid_q;
  assign line_level_o = stat.line;
  assign busy_res_o   = stat.busy;

endmodule

/* hdl/wts_checker.sv */
module wts_checker
  import wts_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [1:0] opcode_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       line_level_o,
  input logic       busy_res_o
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_o;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(line_level_o) && $stable(busy_res_o))
    else $error("result changed while stalled");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted request produced no result");

  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_UPDATE) |=> busy_res_o)
    else $error("update did not start a frame");

  a_idle_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_TICK) && !busy_res_o |=> !busy_res_o && $stable(line_level_o))
    else $error("tick while idle moved the line");

  a_noop_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i != OP_TICK) && (opcode_i != OP_UPDATE)
      |=> $stable(line_level_o) && $stable(busy_res_o))
    else $error("set or unused opcode moved the waveform");

endmodule

bind ws2812_tick_serializer wts_checker u_wts_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .opcode_i     (opcode_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .line_level_o (line_level_o),
  .busy_res_o   (busy_res_o)
);

/* tb/ws2812_tick_serializer_test.sv */
`timescale 1ns / 1ps

module ws2812_tick_serializer_test;
  import wts_pkg::*;

  localparam logic [1:0] OpIgnored     = 2'd3;
  localparam logic [2:0] LedCountAddr  = 3'd0;
  localparam int         RandomItems   = 950;
  localparam int         CycleLimit    = 400000;

  typedef struct {
    logic [1:0] opcode;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } tick_req_t;

  typedef struct {
    logic line;
    logic busy;
  } line_res_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  opcode_i    = OP_TICK;
  logic [7:0]  red_i       = 8'd0;
  logic [7:0]  green_i     = 8'd0;
  logic [7:0]  blue_i      = 8'd0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        line_level_o;
  logic        busy_res_o;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [2:0]  paddr       = LedCountAddr;
  logic [31:0] pwdata      = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  ws2812_tick_serializer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .line_level_o(line_level_o),
    .busy_res_o  (busy_res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // waveform state mirrored from the block
  logic [PixW-1:0]   pixels_cfg   = LedCountReset;
  logic [23:0]       colour_set   = '0;
  logic [23:0]       colour_frame = '0;
  logic [BytesW-1:0] bytes_todo   = '0;
  logic [SlotW-1:0]  slot_q       = '0;
  logic [PhaseW-1:0] phase_q      = '0;
  logic              sending      = 1'b0;
  logic              line_q       = 1'b0;

  tick_req_t tick_req_q[$];
  line_res_t line_expect_q[$];
  int        errors      = 0;
  int        req_count   = 0;
  int        cycle_count = 0;
  logic      req_taken   = 1'b0;

  function automatic line_res_t predict_line(input tick_req_t req);
    logic [7:0]      lane_byte;
    logic            bit_val;
    logic [PixW-1:0] n;
    line_res_t       res;
    case (req.opcode)
      OP_TICK: begin
        if (sending) begin
          if (bytes_todo == '0) begin
            slot_q  = '0;
            phase_q = '0;
            sending = 1'b0;
          end else if (slot_q == '0) begin
            if (phase_q >= PreambleEnd) begin
              slot_q  = SlotW'(1);
              phase_q = PhaseW'(1);
            end else begin
              phase_q++;
            end
            line_q = 1'b0;
          end else begin
            case (lane_e'(bytes_todo % 3))
              LANE_GREEN: lane_byte = colour_frame[23:16];
              LANE_RED:   lane_byte = colour_frame[15:8];
              default:    lane_byte = colour_frame[7:0];
            endcase
            bit_val = lane_byte[3'(LastSlot - slot_q)];
            line_q  = (phase_q <= ZeroEnd) || (bit_val && (phase_q <= OneEnd));
            if (phase_q >= BitEnd) begin
              phase_q = PhaseW'(1);
              if (slot_q >= LastSlot) begin
                slot_q = SlotW'(1);
                bytes_todo--;
              end else begin
                slot_q++;
              end
            end else begin
              phase_q++;
            end
          end
        end
      end
      OP_SET: begin
        colour_set = {req.green, req.red, req.blue};
      end
      OP_UPDATE: begin
        n            = (pixels_cfg > MaxPixels) ? PixW'(MaxPixels) : pixels_cfg;
        colour_frame = colour_set;
        bytes_todo   = BytesW'(3 * n);
        sending      = 1'b1;
      end
      default: ;
    endcase
    res.line = line_q;
    res.busy = sending;
    return res;
  endfunction

  // sender: bursts with random gaps, and now and then a full drain
  int burst_left     = 0;
  int gap_left       = 0;
  bit hold_for_drain = 1'b0;

  always @(negedge clk_i) begin : drive_requests
    tick_req_t req;
    if (rst_ni && (!in_valid_i || req_taken)) begin
      if (hold_for_drain) begin
        in_valid_i <= 1'b0;
        if (line_expect_q.size() == 0) hold_for_drain <= 1'b0;
      end else if (gap_left > 0) begin
        in_valid_i <= 1'b0;
        gap_left   <= gap_left - 1;
      end else if (tick_req_q.size() > 0) begin
        req = tick_req_q.pop_front();
        in_valid_i <= 1'b1;
        opcode_i   <= req.opcode;
        red_i      <= req.red;
        green_i    <= req.green;
        blue_i     <= req.blue;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          if ($urandom_range(0, 40) == 0) hold_for_drain <= 1'b1;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: switch between stall modes every so often
  int stall_mode = 0;
  int stall_left = 0;

  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (cycle_count % 8) < 5;
    endcase
  end

  always @(posedge clk_i) begin : watch_results
    line_res_t want;
    req_taken <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      line_expect_q.push_back(predict_line('{opcode_i, red_i, green_i, blue_i}));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (line_expect_q.size() == 0) begin
        $error("unexpected result: line_level %0b busy_res %0b", line_level_o, busy_res_o);
        errors++;
      end else begin
        want = line_expect_q.pop_front();
        if (line_level_o !== want.line) begin
          $error("line_level: expected %0b, got %0b", want.line, line_level_o);
          errors++;
        end
        if (busy_res_o !== want.busy) begin
          $error("busy_res: expected %0b, got %0b", want.busy, busy_res_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic queue_req(input logic [1:0] op, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    tick_req_t req;
    req.opcode = op;
    req.red    = r;
    req.green  = g;
    req.blue   = b;
    tick_req_q.push_back(req);
    if (op != OpIgnored) req_count++;
  endtask

  // ticks with random colour bits, sprinkled with noise, colour changes and, when enabled, reloads
  task automatic queue_ticks(input int count, input bit reloads);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 39))
        0: queue_req(OpIgnored, 8'($urandom), 8'($urandom), 8'($urandom));
        1: queue_req(OP_SET, 8'($urandom), 8'($urandom), 8'($urandom));
        2: if (reloads) queue_req(OP_UPDATE, 8'($urandom), 8'($urandom), 8'($urandom));
        default: ;
      endcase
      queue_req(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic wait_idle();
    while (tick_req_q.size() > 0 || in_valid_i || line_expect_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_led_count(input logic [8:0] value);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LedCountAddr;
    pwdata  = {23'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    pixels_cfg = value;
    @(negedge clk_i);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {23'd0, value}) begin
      $error("led_count: expected %0d, got %0d", value, prdata);
      errors++;
    end
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  initial begin
    int          lc;
    int          pick;
    bit          full_frame;
    bit          first;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // reset pixel count: idle tick, noise, colour extremes, start, preamble and the head of the first bit
    queue_req(OP_TICK, 8'hFF, 8'hFF, 8'hFF);
    queue_req(OpIgnored, 8'hFF, 8'hFF, 8'hFF);
    queue_req(OP_SET, 8'h00, 8'hFF, 8'h00);
    queue_req(OP_SET, 8'hFF, 8'h00, 8'hFF);
    queue_req(OP_UPDATE, 8'h00, 8'h00, 8'h00);
    repeat (14) queue_req(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_req(OpIgnored, 8'h00, 8'h00, 8'h00);
    queue_req(OP_SET, 8'h5A, 8'hA5, 8'h3C);
    queue_req(OP_TICK, 8'h00, 8'h00, 8'h00);
    wait_idle();

    // empty chain: the frame ends on the next tick, line level kept
    write_led_count(9'd0);
    queue_req(OP_UPDATE, 8'h00, 8'h00, 8'h00);
    queue_req(OP_TICK, 8'h00, 8'h00, 8'h00);
    queue_req(OP_TICK, 8'h00, 8'h00, 8'h00);

    req_count = 0;
    first     = 1'b1;
    while (req_count < RandomItems) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      if (first)          lc = 1;
      else if (pick < 2)  lc = 0;
      else if (pick < 7)  lc = 1;
      else if (pick == 7) lc = $urandom_range(2, 4);
      else if (pick == 8) lc = $urandom_range(0, 1) ? 256 : 511;
      else                lc = $urandom_range(0, 511);
      write_led_count(9'(lc));
      // a full frame runs to the end without reload; others get a short run of ticks with reloads
      full_frame = first || (lc <= 1 && req_count + lc * 620 < RandomItems &&
                             $urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0) queue_req(OP_SET, 8'($urandom), 8'($urandom), 8'($urandom));
      queue_req(OP_UPDATE, 8'($urandom), 8'($urandom), 8'($urandom));
      if (full_frame) queue_ticks(lc * 620 + $urandom_range(5, 30), 1'b0);
      else            queue_ticks($urandom_range(10, 90), 1'b1);
      first = 1'b0;
    end

    wait_idle();
    repeat (5) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
